/* sv/rdsc_pkg.sv */
// ----------------------------------------------------------------------------
// rdsc_pkg
// shared types and constants of the resize drag size constrainer
// ----------------------------------------------------------------------------
package rdsc_pkg;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_LOW  = 2'd1,
      DIR_HIGH = 2'd2
   } dir_type;

   // work width of the constraint datapath, enough for products of 16 x 12 bits
   localparam int WORK_BITS = 36;

   // register indexes
   localparam logic [2:0] REG_ORIGIN_POS  = 3'd0;
   localparam logic [2:0] REG_ORIGIN_SIZE = 3'd1;
   localparam logic [2:0] REG_MIN_SIZE    = 3'd2;
   localparam logic [2:0] REG_MAX_SIZE    = 3'd3;
   localparam logic [2:0] REG_BASE_SIZE   = 3'd4;
   localparam logic [2:0] REG_SIZE_INC    = 3'd5;
   localparam logic [2:0] REG_ASPECT      = 3'd6;
   localparam logic [2:0] REG_FRAME_INFO  = 3'd7;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NOP,
      OP_EDGE,        // apply edge rules, load w/h work registers
      OP_CLAMP,       // strip frame, clamp min/max
      OP_SNAP_W,      // start divide (w-base)/xinc
      OP_SNAP_W_END,  // w = q*xinc + basew
      OP_SNAP_H,
      OP_SNAP_H_END,
      OP_MUL,         // form mnx*h, mny*w, mxx*h, mxy*w
      OP_A1_DIV,      // mnx*h / mny
      OP_A1_SNAP,     // (q - w) / xinc
      OP_A1_END,      // apply w += d
      OP_A2_DIV,      // w*mny / mnx
      OP_A2_SNAP,     // (h - q) / yinc
      OP_A2_END,      // h -= d or go to fallback
      OP_B1_DIV,      // w*mxy / mxx
      OP_B1_SNAP,     // (q - h) / yinc
      OP_B1_END,
      OP_B2_DIV,      // mxx*h / mxy
      OP_B2_SNAP,     // (w - q) / xinc
      OP_B2_END,
      OP_FINISH       // restore frame, store drag rectangle
   } op_type;

   typedef struct packed {
      op_type op;
      logic   act_set;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic act;        // an edge rule fired
      logic aspect_en;
      logic min_ok;     // min aspect terms nonzero
      logic max_ok;
      logic a_gt;       // mnx*h > mny*w
      logic b_lt;       // mxx*h < mxy*w
      logic h_none;
      logic v_none;
      logic a2_fail;    // h - d < minh
      logic b2_fail;
   } stat_type;

endpackage

/* sv/rdsc_divider.sv */
// ----------------------------------------------------------------------------
// rdsc_divider
// signed truncating restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rdsc_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [rdsc_pkg::WORK_BITS-1:0] dividend,
   input  logic        [rdsc_pkg::WORK_BITS-1:0] divisor,
   output logic                               busy,
   output logic signed [rdsc_pkg::WORK_BITS-1:0] quotient
);
   import rdsc_pkg::*;

   localparam int CB = $clog2(WORK_BITS + 1);

   logic [WORK_BITS-1:0] rem_ff, rem_in;
   logic [WORK_BITS-1:0] quo_ff, quo_in;
   logic [WORK_BITS-1:0] den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [WORK_BITS:0]   trial;
   logic [WORK_BITS-1:0] mag;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mag     = dividend[WORK_BITS-1] ? WORK_BITS'(-dividend) : WORK_BITS'(dividend);
      trial   = {rem_ff, quo_ff[WORK_BITS-1]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = mag;
         den_in  = divisor;
         neg_in  = dividend[WORK_BITS-1];
         cnt_in  = CB'(WORK_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORK_BITS]) begin
            rem_in = trial[WORK_BITS-1:0];
            quo_in = {quo_ff[WORK_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORK_BITS-2:0], quo_ff[WORK_BITS-1]};
            quo_in = {quo_ff[WORK_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

/* sv/rdsc_datapath.sv */
// ----------------------------------------------------------------------------
// rdsc_datapath
// edge rules, size hint constraint and drag rectangle registers
// ----------------------------------------------------------------------------
module rdsc_datapath #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rdsc_pkg::cmd_type     cmd,
   output rdsc_pkg::stat_type    stat,
   input  logic signed [15:0]    pointer_x,
   input  logic signed [15:0]    pointer_y,
   input  logic [31:0]           origin_position,
   input  logic [31:0]           origin_size,
   input  logic [31:0]           minimum_size,
   input  logic [31:0]           maximum_size,
   input  logic [31:0]           base_size,
   input  logic [31:0]           size_increment,
   input  logic [47:0]           aspect_limits,
   input  logic [24:0]           frame_info,
   output logic signed [15:0]    outline_x,
   output logic signed [15:0]    outline_y,
   output logic [15:0]           outline_width,
   output logic [15:0]           outline_height,
   output logic [14:0]           frame_width,
   output logic [14:0]           frame_height
);
   import rdsc_pkg::*;

   localparam int W = WORK_BITS;
   typedef logic signed [W-1:0] wk_type;

   wk_type px, py, ox, oy, ow, oh, bnd, title, bw;
   wk_type minw, minh, maxw, maxh, basew, baseh, xinc, yinc;
   wk_type mnx, mny, mxx, mxy;

   assign px    = W'(pointer_x);
   assign py    = W'(pointer_y);
   assign ox    = W'($signed(origin_position[15:0]));
   assign oy    = W'($signed(origin_position[31:16]));
   assign ow    = W'({1'b0, origin_size[15:0]});
   assign oh    = W'({1'b0, origin_size[31:16]});
   assign bnd   = W'({1'b0, frame_info[7:0]});
   assign title = W'({1'b0, frame_info[15:8]});
   assign bw    = W'({1'b0, frame_info[23:16]});
   assign minw  = W'({1'b0, minimum_size[15:0]});
   assign minh  = W'({1'b0, minimum_size[31:16]});
   assign maxw  = W'({1'b0, maximum_size[15:0]});
   assign maxh  = W'({1'b0, maximum_size[31:16]});
   assign basew = W'({1'b0, base_size[15:0]});
   assign baseh = W'({1'b0, base_size[31:16]});
   assign xinc  = (size_increment[15:0] == '0) ? W'(1) : W'({1'b0, size_increment[15:0]});
   assign yinc  = (size_increment[31:16] == '0) ? W'(1) : W'({1'b0, size_increment[31:16]});
   assign mnx   = W'({1'b0, aspect_limits[11:0]});
   assign mny   = W'({1'b0, aspect_limits[23:12]});
   assign mxx   = W'({1'b0, aspect_limits[35:24]});
   assign mxy   = W'({1'b0, aspect_limits[47:36]});

   logic signed [COORD_BITS-1:0] dl_ff, dl_in, dt_ff, dt_in;
   logic [COORD_BITS-1:0]        dw_ff, dw_in, dh_ff, dh_in;
   dir_type                      hd_ff, hd_in, vd_ff, vd_in;
   wk_type w_ff, w_in, h_ff, h_in, dx_ff, dx_in, dy_ff, dy_in;
   wk_type p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, p4_ff, p4_in;
   wk_type t_ff, t_in, d_ff, d_in;
   logic   act_ff, act_in, a2f_ff, a2f_in, b2f_ff, b2f_in;

   // shared divider
   logic   dv_start, dv_busy;
   wk_type dv_num, dv_quo;
   logic [W-1:0] dv_den;

   rdsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (dv_den),
      .busy     (dv_busy),
      .quotient (dv_quo)
   );

   wk_type mul_a, mul_b, mul_p, snap_d;
   wk_type dw_cur, dh_cur, dx_cur, dy_cur;
   logic   vlow, vhigh, hlow, hhigh;
   dir_type hd_mid;

   assign snap_d = mul_p;

   always_comb begin
      dl_in = dl_ff; dt_in = dt_ff; dw_in = dw_ff; dh_in = dh_ff;
      hd_in = hd_ff; vd_in = vd_ff;
      w_in = w_ff; h_in = h_ff; dx_in = dx_ff; dy_in = dy_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff; p4_in = p4_ff;
      t_in = t_ff; d_in = d_ff; act_in = act_ff; a2f_in = a2f_ff; b2f_in = b2f_ff;
      dv_start = 1'b0; dv_num = '0; dv_den = '0;
      mul_a = '0; mul_b = '0;
      dx_cur = W'(dl_ff); dy_cur = W'(dt_ff);
      dw_cur = W'({1'b0, dw_ff}); dh_cur = W'({1'b0, dh_ff});
      vlow = 1'b0; vhigh = 1'b0; hlow = 1'b0; hhigh = 1'b0; hd_mid = hd_ff;
      unique case (cmd.op)
         OP_EDGE: begin
            act_in = 1'b0;
            vlow  = (py <= oy) || (vd_ff == DIR_LOW && py < oy + oh - W'(1));
            vhigh = (py >= oy + oh - W'(1)) || (vd_ff == DIR_HIGH && py > oy);
            if (vlow) begin
               dy_cur = py; dh_cur = oy + oh - py; act_in = 1'b1; vd_in = DIR_LOW;
            end else if (vhigh) begin
               dy_cur = oy; dh_cur = W'(1) + py - oy; act_in = 1'b1; vd_in = DIR_HIGH;
            end
            hlow = (px <= ox) || (hd_ff == DIR_LOW && px < ox + ow - W'(1));
            if (hlow) begin
               dx_cur = px; dw_cur = ox + ow - px; act_in = 1'b1; hd_mid = DIR_LOW;
            end
            hhigh = (px >= ox + ow - W'(1)) || (hd_mid == DIR_HIGH && px > ox);
            if (hhigh) begin
               dx_cur = ox; dw_cur = W'(1) + px - ox; act_in = 1'b1; hd_mid = DIR_HIGH;
            end
            hd_in = hd_mid;
            dx_in = dx_cur; dy_in = dy_cur; w_in = dw_cur; h_in = dh_cur;
         end
         OP_CLAMP: begin
            w_in = w_ff - (bnd <<< 1);
            h_in = h_ff - (title + (bnd <<< 1));
            if (w_in < minw) w_in = minw;
            if (h_in < minh) h_in = minh;
            if (w_in > maxw) w_in = maxw;
            if (h_in > maxh) h_in = maxh;
         end
         OP_SNAP_W: begin
            dv_start = 1'b1; dv_num = w_ff - basew; dv_den = xinc;
         end
         OP_SNAP_W_END: begin
            mul_a = dv_quo; mul_b = xinc; w_in = mul_p + basew;
         end
         OP_SNAP_H: begin
            dv_start = 1'b1; dv_num = h_ff - baseh; dv_den = yinc;
         end
         OP_SNAP_H_END: begin
            mul_a = dv_quo; mul_b = yinc; h_in = mul_p + baseh;
         end
         OP_MUL: begin
            p1_in = mnx * h_ff; p2_in = mny * w_ff;
            p3_in = mxx * h_ff; p4_in = mxy * w_ff;
         end
         OP_A1_DIV: begin
            dv_start = 1'b1; dv_num = mnx * h_ff; dv_den = mny;
         end
         OP_A1_SNAP: begin
            dv_start = 1'b1; dv_num = dv_quo - w_ff; dv_den = xinc;
         end
         OP_A1_END: begin
            mul_a = dv_quo; mul_b = xinc;
            if (w_ff + snap_d <= maxw) w_in = w_ff + snap_d;
         end
         OP_A2_DIV: begin
            dv_start = 1'b1; dv_num = w_ff * mny; dv_den = mnx;
         end
         OP_A2_SNAP: begin
            dv_start = 1'b1; dv_num = h_ff - dv_quo; dv_den = yinc;
         end
         OP_A2_END: begin
            mul_a = dv_quo; mul_b = yinc;
            a2f_in = !(h_ff - snap_d >= minh);
            if (!a2f_in) h_in = h_ff - snap_d;
         end
         OP_B1_DIV: begin
            dv_start = 1'b1; dv_num = w_ff * mxy; dv_den = mxx;
         end
         OP_B1_SNAP: begin
            dv_start = 1'b1; dv_num = dv_quo - h_ff; dv_den = yinc;
         end
         OP_B1_END: begin
            mul_a = dv_quo; mul_b = yinc;
            if (h_ff + snap_d <= maxh) h_in = h_ff + snap_d;
         end
         OP_B2_DIV: begin
            dv_start = 1'b1; dv_num = mxx * h_ff; dv_den = mxy;
         end
         OP_B2_SNAP: begin
            dv_start = 1'b1; dv_num = w_ff - dv_quo; dv_den = xinc;
         end
         OP_B2_END: begin
            mul_a = dv_quo; mul_b = xinc;
            b2f_in = !(w_ff - snap_d >= minw);
            if (!b2f_in) w_in = w_ff - snap_d;
         end
         OP_FINISH: begin
            dw_cur = w_ff + (bnd <<< 1);
            dh_cur = h_ff + title + (bnd <<< 1);
            dx_cur = dx_ff; dy_cur = dy_ff;
            if (hd_ff == DIR_LOW) dx_cur = ox + ow - dw_cur;
            if (vd_ff == DIR_LOW) dy_cur = oy + oh - dh_cur;
            dl_in = dx_cur[COORD_BITS-1:0];
            dt_in = dy_cur[COORD_BITS-1:0];
            dw_in = dw_cur[COORD_BITS-1:0];
            dh_in = dh_cur[COORD_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      w_ff <= w_in; h_ff <= h_in; dx_ff <= dx_in; dy_ff <= dy_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in; p4_ff <= p4_in;
      t_ff <= t_in; d_ff <= d_in; a2f_ff <= a2f_in; b2f_ff <= b2f_in;
      if (reset) begin
         dl_ff <= '0; dt_ff <= '0; dw_ff <= '0; dh_ff <= '0;
         hd_ff <= DIR_NONE; vd_ff <= DIR_NONE; act_ff <= 1'b0;
      end else begin
         dl_ff <= dl_in; dt_ff <= dt_in; dw_ff <= dw_in; dh_ff <= dh_in;
         hd_ff <= hd_in; vd_ff <= vd_in; act_ff <= act_in;
      end
   end

   always_comb begin
      stat.div_busy  = dv_busy;
      stat.act       = act_ff;
      stat.aspect_en = frame_info[24];
      stat.min_ok    = (mnx != '0) && (mny != '0);
      stat.max_ok    = (mxx != '0) && (mxy != '0);
      stat.a_gt      = p1_ff > p2_ff;
      stat.b_lt      = p3_ff < p4_ff;
      stat.h_none    = hd_ff == DIR_NONE;
      stat.v_none    = vd_ff == DIR_NONE;
      stat.a2_fail   = a2f_ff;
      stat.b2_fail   = b2f_ff;
   end

   wk_type odx, ody, odw, odh;
   assign odx = W'(dl_ff);
   assign ody = W'(dt_ff);
   assign odw = W'({1'b0, dw_ff});
   assign odh = W'({1'b0, dh_ff});

   assign outline_x      = 16'(odx - bw);
   assign outline_y      = 16'(ody - bw);
   assign outline_width  = 16'(odw + (bw <<< 1));
   assign outline_height = 16'(odh + (bw <<< 1));
   assign frame_width    = (odw > W'(32767)) ? 15'h7fff : odw[14:0];
   assign frame_height   = (odh > W'(32767)) ? 15'h7fff : odh[14:0];

endmodule

/* sv/rdsc_control.sv */
// ----------------------------------------------------------------------------
// rdsc_control
// sequencer that steps the datapath through the constraint for one item
// ----------------------------------------------------------------------------
module rdsc_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rdsc_pkg::cmd_type   cmd,
   input  rdsc_pkg::stat_type  stat
);
   import rdsc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE, S_CLAMP, S_SW, S_SWW, S_SH, S_SHW, S_MUL, S_SEL,
      S_A1D, S_A1S, S_A1E, S_A2M, S_A2D, S_A2S, S_A2E, S_A2F,
      S_B1D, S_B1S, S_B1E, S_B2M, S_B2D, S_B2S, S_B2E, S_B2F, S_BSEL,
      S_FIN, S_OUT
   } state_type;

   state_type st_ff, st_in;
   state_type ret_ff, ret_in;   // state after divider finishes
   op_type    wop_ff, wop_in;   // fallback marker, picks the state after an end op
   logic      wait_ff, wait_in;

   // issue an op now; if it starts the divider, wait and continue at ret
   always_comb begin
      st_in = st_ff; ret_in = ret_ff; wop_in = wop_ff; wait_in = wait_ff;
      cmd.op = OP_NOP; cmd.act_set = 1'b0;
      if (wait_ff) begin
         if (!stat.div_busy) begin
            wait_in = 1'b0; st_in = ret_ff;
         end
      end else begin
         unique case (st_ff)
            S_IDLE: if (req_valid) st_in = S_EDGE;
            S_EDGE: begin cmd.op = OP_EDGE; st_in = S_CLAMP; end
            S_CLAMP: begin
               if (stat.act) begin cmd.op = OP_CLAMP; st_in = S_SW; end
               else st_in = S_OUT;
            end
            S_SW:  begin cmd.op = OP_SNAP_W; wait_in = 1'b1; ret_in = S_SWW; end
            S_SWW: begin cmd.op = OP_SNAP_W_END; st_in = S_SH; end
            S_SH:  begin cmd.op = OP_SNAP_H; wait_in = 1'b1; ret_in = S_SHW; end
            S_SHW: begin cmd.op = OP_SNAP_H_END; st_in = S_MUL; end
            S_MUL: begin cmd.op = OP_MUL; st_in = S_SEL; end
            S_SEL: begin
               if (!stat.aspect_en) st_in = S_FIN;
               else if (stat.min_ok && stat.a_gt && stat.h_none) st_in = S_A1D;
               else st_in = S_A2M;
            end
            S_A1D: begin cmd.op = OP_A1_DIV; wait_in = 1'b1; ret_in = S_A1S; end
            S_A1S: begin cmd.op = OP_A1_SNAP; wait_in = 1'b1; ret_in = S_A1E; end
            S_A1E: begin cmd.op = OP_A1_END; st_in = wop_ff == OP_A2_END ? S_BSEL : S_A2M; end
            S_A2M: begin cmd.op = OP_MUL; wop_in = OP_NOP; st_in = S_A2D; end
            S_A2D: begin
               if (stat.min_ok && stat.a_gt) begin
                  cmd.op = OP_A2_DIV; wait_in = 1'b1; ret_in = S_A2S;
               end else st_in = S_BSEL;
            end
            S_A2S: begin cmd.op = OP_A2_SNAP; wait_in = 1'b1; ret_in = S_A2E; end
            S_A2E: begin cmd.op = OP_A2_END; st_in = S_A2F; end
            S_A2F: begin
               if (stat.a2_fail) begin wop_in = OP_A2_END; st_in = S_A1D; end
               else st_in = S_BSEL;
            end
            S_BSEL: begin cmd.op = OP_MUL; wop_in = OP_NOP; st_in = S_B1D; end
            S_B1D: begin
               if (stat.max_ok && stat.b_lt && stat.v_none) begin
                  cmd.op = OP_B1_DIV; wait_in = 1'b1; ret_in = S_B1S;
               end else st_in = S_B2M;
            end
            S_B1S: begin cmd.op = OP_B1_SNAP; wait_in = 1'b1; ret_in = S_B1E; end
            S_B1E: begin cmd.op = OP_B1_END; st_in = wop_ff == OP_B2_END ? S_FIN : S_B2M; end
            S_B2M: begin cmd.op = OP_MUL; st_in = S_B2D; end
            S_B2D: begin
               if (stat.max_ok && stat.b_lt) begin
                  cmd.op = OP_B2_DIV; wait_in = 1'b1; ret_in = S_B2S;
               end else st_in = S_FIN;
            end
            S_B2S: begin cmd.op = OP_B2_SNAP; wait_in = 1'b1; ret_in = S_B2E; end
            S_B2E: begin cmd.op = OP_B2_END; st_in = S_B2F; end
            S_B2F: begin
               if (stat.b2_fail) begin
                  wop_in = OP_B2_END; cmd.op = OP_B1_DIV; wait_in = 1'b1; ret_in = S_B1S;
               end else st_in = S_FIN;
            end
            S_FIN: begin cmd.op = OP_FINISH; st_in = S_OUT; end
            S_OUT: if (rsp_ready) st_in = S_IDLE;
            default: st_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ret_ff <= S_IDLE; wop_ff <= OP_NOP; wait_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; wop_ff <= wop_in; wait_ff <= wait_in;
      end
   end

   assign req_ready = (st_ff == S_IDLE) && !wait_ff;
   assign rsp_valid = (st_ff == S_OUT) && !wait_ff;

`ifndef ASSERT_OFF
   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and valid together");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_edge_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> st_ff == S_EDGE) else $error("accept lost");
`endif

endmodule

/* sv/resize_drag_size_constrainer.sv */
// ----------------------------------------------------------------------------
// resize_drag_size_constrainer
// pointer drag to constrained outline rectangle, apb register file
// ----------------------------------------------------------------------------
// when an edge rule fires, the constraint uses the shared 36-step divider two to
// fourteen times; when none fires, the constraint is skipped.
// one item at a time; next item taken after the result is delivered.
// reset is synchronous: registers take their documented values, drag state clears.
module resize_drag_size_constrainer #(
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pointer_x,
   input  logic signed [15:0] req_pointer_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_changed,
   output logic signed [15:0] rsp_outline_x,
   output logic signed [15:0] rsp_outline_y,
   output logic [15:0]        rsp_outline_width,
   output logic [15:0]        rsp_outline_height,
   output logic [14:0]        rsp_frame_width,
   output logic [14:0]        rsp_frame_height,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);
   import rdsc_pkg::*;

   logic [31:0] opos_ff, osz_ff, mins_ff, maxs_ff, base_ff, inc_ff;
   logic [47:0] asp_ff;
   logic [24:0] finfo_ff;
   logic signed [15:0] px_ff, py_ff;
   logic [2:0] ridx;

   assign pready = 1'b1;
   assign ridx   = paddr[5:3];

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff <= req_pointer_x;
         py_ff <= req_pointer_y;
      end
      if (reset) begin
         opos_ff <= '0; osz_ff <= 32'd65537; mins_ff <= '0;
         maxs_ff <= 32'd2147450879; base_ff <= '0; inc_ff <= 32'd65537;
         asp_ff <= '0; finfo_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (ridx)
            REG_ORIGIN_POS:  opos_ff  <= pwdata[31:0];
            REG_ORIGIN_SIZE: osz_ff   <= pwdata[31:0];
            REG_MIN_SIZE:    mins_ff  <= pwdata[31:0];
            REG_MAX_SIZE:    maxs_ff  <= pwdata[31:0];
            REG_BASE_SIZE:   base_ff  <= pwdata[31:0];
            REG_SIZE_INC:    inc_ff   <= pwdata[31:0];
            REG_ASPECT:      asp_ff   <= pwdata[47:0];
            REG_FRAME_INFO:  finfo_ff <= pwdata[24:0];
            default: begin end
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_ORIGIN_POS:  prdata = {32'd0, opos_ff};
         REG_ORIGIN_SIZE: prdata = {32'd0, osz_ff};
         REG_MIN_SIZE:    prdata = {32'd0, mins_ff};
         REG_MAX_SIZE:    prdata = {32'd0, maxs_ff};
         REG_BASE_SIZE:   prdata = {32'd0, base_ff};
         REG_SIZE_INC:    prdata = {32'd0, inc_ff};
         REG_ASPECT:      prdata = {16'd0, asp_ff};
         REG_FRAME_INFO:  prdata = {39'd0, finfo_ff};
         default:         prdata = '0;
      endcase
   end

   cmd_type  cmd;
   stat_type stat;

   rdsc_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rdsc_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .pointer_x       (px_ff),
      .pointer_y       (py_ff),
      .origin_position (opos_ff),
      .origin_size     (osz_ff),
      .minimum_size    (mins_ff),
      .maximum_size    (maxs_ff),
      .base_size       (base_ff),
      .size_increment  (inc_ff),
      .aspect_limits   (asp_ff),
      .frame_info      (finfo_ff),
      .outline_x       (rsp_outline_x),
      .outline_y       (rsp_outline_y),
      .outline_width   (rsp_outline_width),
      .outline_height  (rsp_outline_height),
      .frame_width     (rsp_frame_width),
      .frame_height    (rsp_frame_height)
   );

   assign rsp_changed = stat.act;

endmodule
